>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, disabled while reset is asserted
`define CTSS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion, checked at every edge including during reset
`define CTSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/ctss_pkg.sv
// Package for the clock/temperature seven-segment scanner.
// Constants, digit codes and the active-low segment decoder; no dependencies.
package ctss_pkg;

    localparam int DIGIT_COUNT = 8;
    localparam int IDX_W       = $clog2(DIGIT_COUNT);

    localparam logic [9:0]  SIGN_OFFSET = 10'd512;
    localparam logic [15:0] BLINK_RESET = 16'd500;

    // Digit codes beyond the decimal digits
    localparam logic [3:0] CODE_MINUS = 4'd10;
    localparam logic [3:0] CODE_BLANK = 4'd11;

    // Point lights on this digit only
    localparam logic [IDX_W-1:0] POINT_DIGIT = IDX_W'(6);

    // Active-low segment pattern, bit0 = A ... bit6 = G
    function automatic logic [6:0] seg_decode(input logic [3:0] code);
        logic [6:0] seg;
        case (code)
            4'd0:       seg = 7'h40;
            4'd1:       seg = 7'h79;
            4'd2:       seg = 7'h24;
            4'd3:       seg = 7'h30;
            4'd4:       seg = 7'h19;
            4'd5:       seg = 7'h12;
            4'd6:       seg = 7'h02;
            4'd7:       seg = 7'h78;
            4'd8:       seg = 7'h00;
            4'd9:       seg = 7'h18;
            CODE_MINUS: seg = 7'h3F;
            default:    seg = 7'h7F;
        endcase
        return seg;
    endfunction

endpackage

>>> rtl/core/clock_temp_seven_segment_scanner_top.sv
// Seven-segment scanner for a clock and temperature display.
// Uses ctss_pkg (constants, segment decoder).
//
// Usage:
//   Input channel (in_valid / in_stall): one request is one display refresh
//   carrying hours, minutes, temperature_code, temperature_new and now_ms.
//   Output channel (out_valid / out_stall): each refresh yields eight scan
//   results, digit 0 to digit 7 in order; last_digit marks the eighth.
//   Config channel (cfg_valid / cfg_ready): writes blink_interval_ms; it is
//   always ready and must only be written while the block is idle.
// Sequence:
//   On acceptance the colon check runs and a shared subtract-and-compare
//   unit splits hours, minutes and (on a new temperature) the magnitude
//   into decimal digits, one subtraction per cycle until the remainder
//   is below the divisor. The eight results then leave one per cycle
//   while out_stall is low; in_stall stays high throughout the refresh.
// Reset:
//   Clears the sequencer, stored temperature digits, colon level and last
//   toggle time, and sets the blink interval to 500 ms.
// Stall:
//   A stalled result holds its value; the scan waits on the same digit.
module clock_temp_seven_segment_scanner_top (
    input  logic        clk,
    input  logic        rst_n,
    // refresh request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [4:0]  hours,
    input  logic [5:0]  minutes,
    input  logic [9:0]  temperature_code,
    input  logic        temperature_new,
    input  logic [31:0] now_ms,
    // scan result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  digit_enables,
    output logic [6:0]  segments_n,
    output logic        point_n,
    output logic        colon_level,
    output logic        last_digit,
    // configuration channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] blink_interval_ms
);

    localparam int IDX_W = ctss_pkg::IDX_W;

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    // Conversion phases
    localparam logic [1:0] PH_HRS  = 2'd0;
    localparam logic [1:0] PH_MIN  = 2'd1;
    localparam logic [1:0] PH_THUN = 2'd2;
    localparam logic [1:0] PH_TTEN = 2'd3;

    localparam logic [9:0] DIV_HUNDRED = 10'd100;
    localparam logic [9:0] DIV_TEN     = 10'd10;

    // Control state
    logic [1:0]       state_reg, state_next;
    logic [1:0]       phase_reg, phase_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [15:0]      blink_reg, blink_next;
    logic [31:0]      toggle_time_reg, toggle_time_next;
    logic             colon_reg, colon_next;
    logic [3:0]       thun_reg, thun_next;
    logic [3:0]       tten_reg, tten_next;
    logic [3:0]       tunit_reg, tunit_next;

    // Working registers
    logic [9:0]       work_reg, work_next;
    logic [3:0]       quot_reg, quot_next;
    logic [5:0]       min_reg, min_next;
    logic [9:0]       tmag_reg, tmag_next;
    logic             fresh_reg, fresh_next;
    logic             minus_reg, minus_next;
    logic [3:0]       htens_reg, htens_next;
    logic [3:0]       hunit_reg, hunit_next;
    logic [3:0]       mtens_reg, mtens_next;
    logic [3:0]       munit_reg, munit_next;

    logic             in_acc;
    logic             out_acc;
    logic             code_gt;
    logic [31:0]      elapsed;
    logic [9:0]       divisor;
    logic             can_sub;
    logic [3:0]       shown;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = (state_reg == ST_EMIT);
    assign out_acc   = out_valid && !out_stall;
    assign cfg_ready = 1'b1;

    assign code_gt = (temperature_code > ctss_pkg::SIGN_OFFSET);
    assign elapsed = now_ms - toggle_time_reg;

    // Shared subtract-and-compare unit
    assign divisor = (phase_reg == PH_THUN) ? DIV_HUNDRED : DIV_TEN;
    assign can_sub = (work_reg >= divisor);

    // Sequencer and datapath next values
    always_comb
    begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        idx_next         = idx_reg;
        blink_next       = blink_reg;
        toggle_time_next = toggle_time_reg;
        colon_next       = colon_reg;
        thun_next        = thun_reg;
        tten_next        = tten_reg;
        tunit_next       = tunit_reg;
        work_next        = work_reg;
        quot_next        = quot_reg;
        min_next         = min_reg;
        tmag_next        = tmag_reg;
        fresh_next       = fresh_reg;
        minus_next       = minus_reg;
        htens_next       = htens_reg;
        hunit_next       = hunit_reg;
        mtens_next       = mtens_reg;
        munit_next       = munit_reg;

        if (cfg_valid && cfg_ready)
        begin
            blink_next = blink_interval_ms;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    // Latch the request, fold the sign, check the colon
                    work_next  = {5'd0, hours};
                    quot_next  = 4'd0;
                    min_next   = minutes;
                    fresh_next = temperature_new;
                    minus_next = temperature_new && code_gt;
                    tmag_next  = code_gt ? (temperature_code - ctss_pkg::SIGN_OFFSET)
                                         : temperature_code;
                    if (elapsed > {16'd0, blink_reg})
                    begin
                        toggle_time_next = now_ms;
                        colon_next       = !colon_reg;
                    end
                    phase_next = PH_HRS;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (can_sub)
                begin
                    // Subtract once more and count the quotient
                    work_next = work_reg - divisor;
                    quot_next = quot_reg + 4'd1;
                end
                else
                begin
                    // Phase done: drop quotient and remainder into place
                    quot_next = 4'd0;
                    case (phase_reg)
                        PH_HRS:
                        begin
                            htens_next = quot_reg;
                            hunit_next = work_reg[3:0];
                            work_next  = {4'd0, min_reg};
                            phase_next = PH_MIN;
                        end
                        PH_MIN:
                        begin
                            mtens_next = quot_reg;
                            munit_next = work_reg[3:0];
                            if (fresh_reg)
                            begin
                                work_next  = tmag_reg;
                                phase_next = PH_THUN;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = ST_EMIT;
                            end
                        end
                        PH_THUN:
                        begin
                            thun_next  = quot_reg;
                            phase_next = PH_TTEN;
                        end
                        default:
                        begin
                            tten_next  = quot_reg;
                            tunit_next = work_reg[3:0];
                            idx_next   = '0;
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_EMIT:
            begin
                // Advance the scan on each taken result
                if (out_acc)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == IDX_W'(ctss_pkg::DIGIT_COUNT - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            phase_reg       <= PH_HRS;
            idx_reg         <= '0;
            blink_reg       <= ctss_pkg::BLINK_RESET;
            toggle_time_reg <= 32'd0;
            colon_reg       <= 1'b0;
            thun_reg        <= 4'd0;
            tten_reg        <= 4'd0;
            tunit_reg       <= 4'd0;
        end
        else
        begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            idx_reg         <= idx_next;
            blink_reg       <= blink_next;
            toggle_time_reg <= toggle_time_next;
            colon_reg       <= colon_next;
            thun_reg        <= thun_next;
            tten_reg        <= tten_next;
            tunit_reg       <= tunit_next;
        end
    end

    // Working registers, no reset needed
    always_ff @(posedge clk)
    begin
        work_reg  <= work_next;
        quot_reg  <= quot_next;
        min_reg   <= min_next;
        tmag_reg  <= tmag_next;
        fresh_reg <= fresh_next;
        minus_reg <= minus_next;
        htens_reg <= htens_next;
        hunit_reg <= hunit_next;
        mtens_reg <= mtens_next;
        munit_reg <= munit_next;
    end

    // Select the digit code for the current scan position
    always_comb
    begin
        case (idx_reg)
            3'd0:    shown = htens_reg;
            3'd1:    shown = hunit_reg;
            3'd2:    shown = mtens_reg;
            3'd3:    shown = munit_reg;
            3'd4:    shown = minus_reg ? ctss_pkg::CODE_MINUS : ctss_pkg::CODE_BLANK;
            3'd5:    shown = thun_reg;
            3'd6:    shown = tten_reg;
            default: shown = tunit_reg;
        endcase
    end

    // Result payload
    assign digit_enables = 8'd1 << idx_reg;
    assign segments_n    = ctss_pkg::seg_decode(shown);
    assign point_n       = (idx_reg != ctss_pkg::POINT_DIGIT);
    assign colon_level   = colon_reg;
    assign last_digit    = (idx_reg == IDX_W'(ctss_pkg::DIGIT_COUNT - 1));

endmodule

>>> rtl/core/ctss_checker.sv
// Port-level checker for the seven-segment scanner, bound to the top level.
// Uses assert_macros.svh.
`include "assert_macros.svh"

module ctss_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] digit_enables,
    input logic       point_n,
    input logic       colon_level,
    input logic       last_digit
);

    // No new request is taken while a scan is under way
    `CTSS_ASSERT(a_busy_scan, clk, rst_n, out_valid |-> in_stall, "request accepted during scan")

    // Exactly one digit is selected per result
    `CTSS_ASSERT(a_onehot, clk, rst_n, out_valid |-> $onehot(digit_enables), "digit select not one-hot")

    // Point and last-digit marks sit on their own digits
    `CTSS_ASSERT(a_marks, clk, rst_n, out_valid |-> ((point_n == !digit_enables[6]) && (last_digit == digit_enables[7])), "point or last mark on wrong digit")

    // Colon holds across all results of one refresh
    `CTSS_ASSERT(a_colon_hold, clk, rst_n, (out_valid && !out_stall && !last_digit) |=> (out_valid && $stable(colon_level)), "colon changed inside refresh")

endmodule

bind clock_temp_seven_segment_scanner_top ctss_checker u_ctss_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .digit_enables (digit_enables),
    .point_n       (point_n),
    .colon_level   (colon_level),
    .last_digit    (last_digit)
);

>>> sim/clock_temp_seven_segment_scanner_top_tb.sv
`timescale 1ns / 100ps
// Testbench for the clock/temperature seven-segment scanner: drives refresh requests and
// blink interval writes, predicts the eight scan results of each refresh and checks them.
// Depends on ctss_pkg and clock_temp_seven_segment_scanner_top.

// One scan result as seen on the output channel
typedef struct {
    logic [7:0] digit_enables;
    logic [6:0] segments_n;
    logic       point_n;
    logic       colon_level;
    logic       last_digit;
} scan_t;

// Display predictor and queue of awaited scan results
class scan_scoreboard;
    bit [15:0] blink_ms;
    bit [3:0]  temp_digits[3];
    bit [31:0] toggle_stamp;
    bit        colon;
    bit [6:0]  glyph[16];
    scan_t     awaited[$];
    int        mismatches;

    function new();
        blink_ms     = ctss_pkg::BLINK_RESET;
        temp_digits  = '{4'd0, 4'd0, 4'd0};
        toggle_stamp = '0;
        colon        = 1'b0;
        mismatches   = 0;
        // active-low shapes: 0-9, minus, then blank
        glyph = '{7'h40, 7'h79, 7'h24, 7'h30, 7'h19, 7'h12, 7'h02, 7'h78,
                  7'h00, 7'h18, 7'h3F, 7'h7F, 7'h7F, 7'h7F, 7'h7F, 7'h7F};
    endfunction

    function void set_interval(bit [15:0] v);
        blink_ms = v;
    endfunction

    function int pending();
        return awaited.size();
    endfunction

    function void report_mismatch(string what);
        mismatches++;
        $display("mismatch: %s", what);
    endfunction

    // Note an accepted refresh request and queue its eight scan results
    function void note_refresh(bit [4:0] hrs, bit [5:0] mins, bit [9:0] code, bit fresh,
                               bit [31:0] now);
        bit [3:0]  shown[8];
        bit [9:0]  mag;
        bit [31:0] elapsed;
        scan_t     s;
        shown[4] = ctss_pkg::CODE_BLANK;
        if (fresh)
        begin
            mag = code;
            if (code > ctss_pkg::SIGN_OFFSET)
            begin
                shown[4] = ctss_pkg::CODE_MINUS;
                mag      = code - ctss_pkg::SIGN_OFFSET;
            end
            temp_digits[0] = 4'(mag / 100);
            temp_digits[1] = 4'((mag % 100) / 10);
            temp_digits[2] = 4'(mag % 10);
        end
        shown[0] = 4'(hrs / 10);
        shown[1] = 4'(hrs % 10);
        shown[2] = 4'(mins / 10);
        shown[3] = 4'(mins % 10);
        shown[5] = temp_digits[0];
        shown[6] = temp_digits[1];
        shown[7] = temp_digits[2];
        // toggle the colon at most once per refresh, modulo 2^32
        elapsed = now - toggle_stamp;
        if (elapsed > {16'd0, blink_ms})
        begin
            toggle_stamp = now;
            colon        = ~colon;
        end
        for (int k = 0; k < ctss_pkg::DIGIT_COUNT; k++)
        begin
            s.digit_enables = 8'(1 << k);
            s.segments_n    = glyph[shown[k]];
            s.point_n       = (k != ctss_pkg::POINT_DIGIT);
            s.colon_level   = colon;
            s.last_digit    = (k == ctss_pkg::DIGIT_COUNT - 1);
            awaited.push_back(s);
        end
    endfunction

    // Compare one accepted scan result with the oldest awaited one
    function void check_scan(scan_t got);
        scan_t want;
        if (awaited.size() == 0)
        begin
            report_mismatch($sformatf("scan result %h/%h with nothing awaited",
                                      got.digit_enables, got.segments_n));
            return;
        end
        want = awaited.pop_front();
        if (got.digit_enables !== want.digit_enables)
            report_mismatch($sformatf("digit_enables got %h want %h",
                                      got.digit_enables, want.digit_enables));
        if (got.segments_n !== want.segments_n)
            report_mismatch($sformatf("segments_n got %h want %h on digits %h",
                                      got.segments_n, want.segments_n, want.digit_enables));
        if (got.point_n !== want.point_n)
            report_mismatch($sformatf("point_n got %b want %b on digits %h",
                                      got.point_n, want.point_n, want.digit_enables));
        if (got.colon_level !== want.colon_level)
            report_mismatch($sformatf("colon_level got %b want %b on digits %h",
                                      got.colon_level, want.colon_level, want.digit_enables));
        if (got.last_digit !== want.last_digit)
            report_mismatch($sformatf("last_digit got %b want %b on digits %h",
                                      got.last_digit, want.last_digit, want.digit_enables));
    endfunction
endclass

module clock_temp_seven_segment_scanner_top_tb;

    localparam int CYCLE_LIMIT = 300000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [9:0]  temperature_code;
    logic        temperature_new;
    logic [31:0] now_ms;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  digit_enables;
    logic [6:0]  segments_n;
    logic        point_n;
    logic        colon_level;
    logic        last_digit;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] blink_interval_ms;

    scan_scoreboard sb;
    bit [31:0]      now_track;
    bit             calm;
    int             cycles;

    clock_temp_seven_segment_scanner_top u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .hours             (hours),
        .minutes           (minutes),
        .temperature_code  (temperature_code),
        .temperature_new   (temperature_new),
        .now_ms            (now_ms),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .digit_enables     (digit_enables),
        .segments_n        (segments_n),
        .point_n           (point_n),
        .colon_level       (colon_level),
        .last_digit        (last_digit),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .blink_interval_ms (blink_interval_ms)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Stall the result channel at random, except during the calm stretch
    always @(negedge clk)
    begin
        out_stall <= rst_n && !calm && ($urandom_range(0, 99) < 20);
    end

    // Check every accepted scan result
    always @(posedge clk)
    begin
        scan_t got;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            got.digit_enables = digit_enables;
            got.segments_n    = segments_n;
            got.point_n       = point_n;
            got.colon_level   = colon_level;
            got.last_digit    = last_digit;
            sb.check_scan(got);
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Issue one refresh request; drops valid at the falling edge after acceptance
    task automatic send_refresh(input bit [4:0] hrs, input bit [5:0] mins,
                                input bit [9:0] code, input bit fresh, input bit [31:0] now);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 20)
            @(negedge clk);
        in_valid         <= 1'b1;
        hours            <= hrs;
        minutes          <= mins;
        temperature_code <= code;
        temperature_new  <= fresh;
        now_ms           <= now;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        sb.note_refresh(hrs, mins, code, fresh, now);
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Wait until every scan result has arrived
    task automatic drain(input int settle);
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    // Write the blink interval while the scanner is idle
    task automatic write_blink(input bit [15:0] v);
        drain(4);
        cfg_valid         <= 1'b1;
        blink_interval_ms <= v;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        sb.set_interval(v);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random refresh: mostly valid time of day, time advancing around the interval
    task automatic random_refresh();
        bit [4:0] hrs;
        bit [5:0] mins;
        bit [9:0] code;
        bit       fresh;
        int       sel;
        int       span;
        hrs  = ($urandom_range(0, 99) < 85) ? 5'($urandom_range(0, 23))
                                            : 5'($urandom_range(24, 31));
        mins = ($urandom_range(0, 99) < 85) ? 6'($urandom_range(0, 59))
                                            : 6'($urandom_range(60, 63));
        sel = $urandom_range(0, 9);
        case (sel)
            0:       code = 10'd512;
            1:       code = 10'd513;
            2:       code = 10'd511;
            3:       code = 10'd1023;
            4:       code = 10'd0;
            default: code = 10'($urandom_range(0, 1023));
        endcase
        fresh = ($urandom_range(0, 99) < 70);
        span  = 2 * int'(sb.blink_ms) + 2;
        if ($urandom_range(0, 9) == 0)
            now_track = $urandom;
        else
            now_track = now_track + 32'($urandom_range(0, span));
        send_refresh(hrs, mins, code, fresh, now_track);
    endtask

    initial
    begin
        sb                = new();
        calm              = 1'b0;
        cycles            = 0;
        rst_n             = 1'b0;
        in_valid          = 1'b0;
        hours             = '0;
        minutes           = '0;
        temperature_code  = '0;
        temperature_new   = 1'b0;
        now_ms            = '0;
        out_stall         = 1'b0;
        cfg_valid         = 1'b0;
        blink_interval_ms = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed refreshes with the reset interval
        send_refresh(5'd0,  6'd0,  10'd0,    1'b1, 32'd0);        // no toggle at zero
        send_refresh(5'd23, 6'd59, 10'd1023, 1'b1, 32'd500);      // elapsed equals interval
        send_refresh(5'd31, 6'd63, 10'd512,  1'b1, 32'd501);      // 512 is positive
        send_refresh(5'd12, 6'd34, 10'd513,  1'b1, 32'd600);      // smallest negative
        send_refresh(5'd9,  6'd5,  10'd999,  1'b0, 32'd1001);     // keep digits, blank sign
        send_refresh(5'd10, 6'd10, 10'd511,  1'b1, 32'd1002);
        send_refresh(5'd24, 6'd60, 10'd1,    1'b0, 32'hFFFF_FFFF);
        send_refresh(5'd1,  6'd1,  10'd100,  1'b1, 32'h0000_00F3); // elapsed wraps, small
        send_refresh(5'd2,  6'd2,  10'd900,  1'b1, 32'h0000_0300);
        send_refresh(5'd19, 6'd45, 10'd250,  1'b1, 32'hAAAA_5555);
        send_refresh(5'd20, 6'd30, 10'd768,  1'b1, 32'h5555_AAAA);
        send_refresh(5'd7,  6'd8,  10'd0,    1'b0, 32'h5555_AAAA);
        send_refresh(5'd21, 6'd42, 10'd682,  1'b1, 32'h5555_AD00);
        send_refresh(5'd10, 6'd21, 10'd341,  1'b1, 32'h5555_AD01);
        send_refresh(5'd15, 6'd0,  10'd1022, 1'b0, 32'h5556_0000);
        now_track = 32'h5556_0000;

        // Shortest interval: colon toggles on most refreshes
        write_blink(16'd1);
        repeat (60) random_refresh();

        // Longest interval
        write_blink(16'hFFFF);
        repeat (60) random_refresh();

        // Random interval, no idling on either side, one full drain midway
        write_blink(16'($urandom_range(2, 65534)));
        calm = 1'b1;
        repeat (35) random_refresh();
        drain(0);
        repeat (35) random_refresh();
        calm = 1'b0;

        // Back to the reset value
        write_blink(ctss_pkg::BLINK_RESET);
        repeat (60) random_refresh();

        drain(40);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
